// ----- design/rs485_frame_checker_crc8_top_macros.svh -----
// Assertion helpers for the frame checker top level.
`ifndef RS485_FRAME_CHECKER_CRC8_TOP_MACROS_SVH
`define RS485_FRAME_CHECKER_CRC8_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define RFC_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only.
`define RFC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rfc_pkg.sv -----
`timescale 1ns / 1ps
package rfc_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic [7:0] trans_id;
    logic [7:0] payload_len;
  } out_item_t;

  localparam logic [2:0] VERDICT_OK       = 3'd0;
  localparam logic [2:0] VERDICT_BAD_HDR  = 3'd1;
  localparam logic [2:0] VERDICT_LEN_BIG  = 3'd2;
  localparam logic [2:0] VERDICT_BAD_TAIL = 3'd3;
  localparam logic [2:0] VERDICT_CRC_ERR  = 3'd4;

  localparam logic [7:0] HDR_MARK    = 8'hAA;
  localparam logic [7:0] TAIL_MARK   = 8'hBB;
  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] ID_OFFSET   = 8'd2;
  localparam logic [7:0] LEN_OFFSET  = 8'd16;
  localparam logic [8:0] DATA_OFFSET = 9'd17;
  localparam int         BUF_MARGIN  = 34;

  // One byte of reflected CRC-8, eight shift steps.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/rfc_in_stage.sv -----
`timescale 1ns / 1ps
module rfc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rfc_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              in_stall,
  output logic              s1_valid,
  output rfc_pkg::in_item_t s1_item
);
  import rfc_pkg::*;

  logic     s1_valid_r;
  in_item_t s1_item_r;

  // Hold the item while the checker cannot retire it.
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// ----- design/rfc_check.sv -----
`timescale 1ns / 1ps
module rfc_check #(
  parameter int RX_BUF_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  rfc_pkg::in_item_t  item,
  input  logic               advance,
  output logic               res_valid,
  output rfc_pkg::out_item_t res
);
  import rfc_pkg::*;

  localparam logic [7:0] LenLimit = 8'(RX_BUF_BYTES - BUF_MARGIN);

  logic [7:0] byte_pos_r, running_crc_r, len_seen_r, id_seen_r;
  logic       frame_active_r;

  logic [7:0] pos, crc, len_cur, id_cur, b;
  logic [7:0] id_nxt, len_nxt;
  logic [8:0] pos9, tail0;
  logic       active, emit;
  logic [2:0] code;
  logic       fire;

  assign b = item.rx_byte;

  always_comb begin
    // A start flag restarts the frame, dropping anything unfinished.
    pos     = item.frame_start ? 8'd0 : byte_pos_r;
    crc     = item.frame_start ? 8'd0 : running_crc_r;
    len_cur = item.frame_start ? 8'd0 : len_seen_r;
    id_cur  = item.frame_start ? 8'd0 : id_seen_r;
    active  = item.frame_start || frame_active_r;
    pos9    = {1'b0, pos};
    tail0   = {1'b0, len_cur} + DATA_OFFSET;
    id_nxt  = id_cur;
    len_nxt = len_cur;
    emit    = 1'b0;
    code    = VERDICT_OK;
    if (active) begin
      if (pos < ID_OFFSET) begin
        if (b != HDR_MARK) begin
          emit = 1'b1;
          code = VERDICT_BAD_HDR;
        end
      end else if (pos == ID_OFFSET) begin
        id_nxt = b;
      end else if (pos == LEN_OFFSET) begin
        len_nxt = b;
        if (b >= LenLimit) begin
          emit = 1'b1;
          code = VERDICT_LEN_BIG;
        end
      end else if (pos > LEN_OFFSET) begin
        if (pos9 == tail0 || pos9 == tail0 + 9'd1) begin
          if (b != TAIL_MARK) begin
            emit = 1'b1;
            code = VERDICT_BAD_TAIL;
          end
        end else if (pos9 == tail0 + 9'd2) begin
          emit = 1'b1;
          code = (b == crc) ? VERDICT_OK : VERDICT_CRC_ERR;
        end
      end
    end
  end

  assign res_valid       = item_valid && emit;
  assign res.verdict     = code;
  assign res.trans_id    = id_nxt;
  assign res.payload_len = len_nxt;

  assign fire = item_valid && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r     <= 8'd0;
      running_crc_r  <= 8'd0;
      len_seen_r     <= 8'd0;
      id_seen_r      <= 8'd0;
      frame_active_r <= 1'b0;
    end else if (fire && active) begin
      id_seen_r  <= id_nxt;
      len_seen_r <= len_nxt;
      if (emit) begin
        // Verdict given: close the frame and drop bytes until the next start.
        byte_pos_r     <= pos;
        running_crc_r  <= crc;
        frame_active_r <= 1'b0;
      end else begin
        byte_pos_r     <= pos + 8'd1;
        running_crc_r  <= crc8_step(crc, b);
        frame_active_r <= 1'b1;
      end
    end
  end

endmodule

// ----- design/rfc_out_stage.sv -----
`timescale 1ns / 1ps
module rfc_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  rfc_pkg::out_item_t res,
  input  logic               out_stall,
  output logic               out_valid,
  output rfc_pkg::out_item_t out_item
);
  import rfc_pkg::*;

  logic      out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- design/rs485_frame_checker_crc8_top.sv -----
`timescale 1ns / 1ps
// Path: a byte waits in the input register until the checker can retire it; its verdict is
//   loaded into the result register (input reg, result reg) and can transfer out from there.
// Throughput: one byte per cycle unless the held byte makes a verdict while the result
//   register holds a stalled one; byte-wide CRC and position checks are combinational.
// Reset: synchronous, active low; clears both valid flags and the frame state, so the
//   block waits for a frame start.
module rs485_frame_checker_crc8_top #(
  parameter int RX_BUF_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  rfc_pkg::in_item_t  in_item,
  output logic               in_stall,
  output logic               out_valid,
  output rfc_pkg::out_item_t out_item,
  input  logic               out_stall
);
  import rfc_pkg::*;
  `include "rs485_frame_checker_crc8_top_macros.svh"

  logic      s1_valid;
  in_item_t  s1_item;
  logic      chk_res_valid;
  out_item_t chk_res;
  logic      advance;
  logic      res_load;

  // Retire the held byte unless it makes a verdict and the result register
  // is still occupied by a verdict that has not transferred out.
  assign advance  = !chk_res_valid || !out_valid || !out_stall;
  assign res_load = s1_valid && advance && chk_res_valid;

  // Input register: one received byte and its start flag.
  rfc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .advance  (advance),
    .in_stall (in_stall),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Header, length, tail and CRC checks against the running frame state.
  rfc_check #(
    .RX_BUF_BYTES (RX_BUF_BYTES)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid),
    .item       (s1_item),
    .advance    (advance),
    .res_valid  (chk_res_valid),
    .res        (chk_res)
  );

  // Result register: one verdict waiting for transfer.
  rfc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res       (chk_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // A verdict taken from the checker must show up in the result register.
  `RFC_ASSERT_NEXT(a_load_lands, clk, rst_n, res_load, out_valid, "verdict lost after load")
  // Back-pressure only while a byte is held.
  `RFC_ASSERT_SAME(a_stall_held, clk, rst_n, in_stall, s1_valid, "stall with empty input reg")
  // Never overwrite a verdict that is still waiting.
  `RFC_ASSERT_SAME(a_no_overrun, clk, rst_n, out_valid && out_stall, !res_load,
    "pending verdict overwritten")
  // Verdict codes stay within the defined set.
  `RFC_ASSERT_SAME(a_code_range, clk, rst_n, out_valid, out_item.verdict <= VERDICT_CRC_ERR,
    "undefined verdict code")

endmodule

// ----- tb/rs485_frame_checker_crc8_top_tb.sv -----
`timescale 1ns / 1ps
module rs485_frame_checker_crc8_top_tb;
  import rfc_pkg::*;

  localparam int RX_BUF_BYTES = 64;
  // Lengths at or above this limit must be flagged as too large.
  localparam int LEN_LIMIT    = RX_BUF_BYTES - BUF_MARGIN;
  localparam int LIVE_TARGET  = 1750;

  typedef enum int {
    FRM_GOOD,
    FRM_BAD_HDR0,
    FRM_BAD_HDR1,
    FRM_LEN_BIG,
    FRM_BAD_TAIL0,
    FRM_BAD_TAIL1,
    FRM_CRC_BAD,
    FRM_RESTART,
    FRM_NOISE
  } frame_kind_t;

  // One queued byte; hold makes the sender wait until every verdict is in.
  typedef struct {
    in_item_t item;
    bit       hold;
  } pend_byte_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;
  logic      out_stall = 1'b0;

  pend_byte_t byte_q[$];     // bytes waiting to be sent
  out_item_t  verdict_q[$];  // verdicts predicted but not yet seen
  int         byte_total  = 0;
  int         loaded_cnt  = 0;
  int         sent_cnt    = 0;
  int         live_bytes  = 0;
  int         err_cnt     = 0;

  // Frame tracker state, mirrors what the checker keeps per frame.
  logic [7:0] fr_pos  = '0;
  logic [7:0] fr_crc  = '0;
  logic [7:0] fr_len  = '0;
  logic [7:0] fr_id   = '0;
  bit         fr_live = 1'b0;

  rs485_frame_checker_crc8_top #(
    .RX_BUF_BYTES(RX_BUF_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_item (out_item),
    .out_stall(out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Reflected CRC-8, one data bit per step, LSB first.
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] din);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ din[i];
      r  = {1'b0, r[7:1]} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // Idle percentage per side: receiver-heavy gaps first, then sender-heavy, then none.
  function automatic int idle_pct(input bit sender_side);
    int ph;
    ph = (byte_total == 0) ? 0 : (loaded_cnt * 3) / byte_total;
    case (ph)
      0:       return sender_side ? 36 : 69;
      1:       return sender_side ? 69 : 36;
      default: return 0;
    endcase
  endfunction

  // Advance the frame tracker by one transferred byte; queue a verdict if one is due.
  task automatic track_byte(input in_item_t it);
    out_item_t  res;
    bit         give;
    logic [8:0] tail_at;
    res  = '0;
    give = 1'b0;
    if (it.frame_start) begin
      fr_pos  = '0;
      fr_crc  = '0;
      fr_len  = '0;
      fr_id   = '0;
      fr_live = 1'b1;
    end
    if (!fr_live) return;
    tail_at = DATA_OFFSET + fr_len;
    if (fr_pos < 2) begin
      if (it.rx_byte != HDR_MARK) begin
        give        = 1'b1;
        res.verdict = VERDICT_BAD_HDR;
      end
    end else if (fr_pos == ID_OFFSET) begin
      fr_id = it.rx_byte;
    end else if (fr_pos == LEN_OFFSET) begin
      fr_len = it.rx_byte;
      if (fr_len >= LEN_LIMIT) begin
        give        = 1'b1;
        res.verdict = VERDICT_LEN_BIG;
      end
    end else if (fr_pos > LEN_OFFSET) begin
      if (fr_pos == tail_at || fr_pos == tail_at + 1) begin
        if (it.rx_byte != TAIL_MARK) begin
          give        = 1'b1;
          res.verdict = VERDICT_BAD_TAIL;
        end
      end else if (fr_pos == tail_at + 2) begin
        give        = 1'b1;
        res.verdict = (it.rx_byte == fr_crc) ? VERDICT_OK : VERDICT_CRC_ERR;
      end
    end
    if (give) begin
      res.trans_id    = fr_id;
      res.payload_len = fr_len;
      verdict_q.push_back(res);
      fr_live = 1'b0;
    end else begin
      fr_crc = crc8_next(fr_crc, it.rx_byte);
      fr_pos = fr_pos + 8'd1;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input bit s, input bit h);
    pend_byte_t e;
    e.item.rx_byte     = b;
    e.item.frame_start = s;
    e.hold             = h;
    byte_q.push_back(e);
  endtask

  // Build one frame of the given kind with random content and queue its bytes.
  task automatic add_frame(input frame_kind_t kind, input bit hold_first);
    logic [7:0] fb[$];
    logic [7:0] plen;
    logic [7:0] acc;
    logic [7:0] bad;
    int         pick;
    int         tail;
    int         keep;
    int         live;
    if (kind == FRM_NOISE) begin
      // Stray bytes with no frame start: ignored unless a cut frame is still open.
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 1'b0);
      return;
    end
    pick = $urandom_range(0, 3);
    plen = (pick == 0) ? 8'd0 :
           (pick == 1) ? 8'(LEN_LIMIT - 1) : 8'($urandom_range(0, LEN_LIMIT - 1));
    tail = 17 + plen;
    for (int i = 0; i < tail + 2; i++) fb.push_back(8'($urandom));
    fb[0]        = HDR_MARK;
    fb[1]        = HDR_MARK;
    fb[16]       = plen;
    fb[tail]     = TAIL_MARK;
    fb[tail + 1] = TAIL_MARK;
    do bad = 8'($urandom); while (bad == HDR_MARK || bad == TAIL_MARK);
    live = tail + 3;
    case (kind)
      FRM_BAD_HDR0: begin
        fb[0] = bad;
        live  = 1;
      end
      FRM_BAD_HDR1: begin
        fb[1] = bad;
        live  = 2;
      end
      FRM_LEN_BIG: begin
        pick   = $urandom_range(0, 2);
        fb[16] = (pick == 0) ? 8'(LEN_LIMIT) :
                 (pick == 1) ? 8'hFF : 8'($urandom_range(LEN_LIMIT, 255));
        live   = 17;
      end
      FRM_BAD_TAIL0: begin
        fb[tail] = bad;
        live     = tail + 1;
      end
      FRM_BAD_TAIL1: begin
        fb[tail + 1] = bad;
        live         = tail + 2;
      end
      default: ;
    endcase
    acc = '0;
    foreach (fb[i]) acc = crc8_next(acc, fb[i]);
    fb.push_back((kind == FRM_CRC_BAD) ? (acc ^ 8'($urandom_range(1, 255))) : acc);
    // Keep only a few ignored bytes past an early verdict.
    keep = live + $urandom_range(0, 2);
    if (kind == FRM_RESTART) begin
      // Drop the frame before its check byte; the next start must abandon it.
      keep = $urandom_range(1, fb.size() - 1);
      live = keep;
    end
    if (keep > fb.size()) keep = fb.size();
    for (int i = 0; i < keep; i++) push_byte(fb[i], i == 0, (i == 0) && hold_first);
    live_bytes += live;
    if (kind != FRM_RESTART) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
        push_byte(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  // Sender: present the next queued byte, hold it until it transfers, and
  // feed every transfer into the frame tracker.
  always @(posedge clk) begin : drive_proc
    pend_byte_t nxt;
    bit         take_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        track_byte(in_item);
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        take_next = 1'b0;
        if (byte_q.size() != 0) begin
          if (byte_q[0].hold && verdict_q.size() != 0) begin
            // Hold off until every outstanding verdict has drained.
            take_next = 1'b0;
          end else begin
            byte_q[0].hold = 1'b0;
            take_next = ($urandom_range(0, 99) >= idle_pct(1'b1));
          end
        end
        if (take_next) begin
          nxt = byte_q.pop_front();
          loaded_cnt++;
          in_valid <= 1'b1;
          in_item  <= nxt.item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random and check each verdict transfer against the oldest prediction.
  always @(posedge clk) begin : watch_proc
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict: expected none, actual verdict=%0d id=%02h len=%02h",
                   $time, out_item.verdict, out_item.trans_id, out_item.payload_len);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (out_item.verdict !== want.verdict || out_item.trans_id !== want.trans_id ||
              out_item.payload_len !== want.payload_len) begin
            $display("%0t: expected verdict=%0d id=%02h len=%02h, %s%0d id=%02h len=%02h",
                     $time, want.verdict, want.trans_id, want.payload_len, "actual verdict=",
                     out_item.verdict, out_item.trans_id, out_item.payload_len);
            err_cnt++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
    end
  end

  initial begin : main_seq
    logic [7:0]  acc;
    logic [7:0]  dir_frame[$];
    int          frame_no;
    int          roll;
    frame_kind_t kind;

    // Directed: shortest good frame with all-ones id and filler.
    dir_frame = '{HDR_MARK, HDR_MARK};
    repeat (14) dir_frame.push_back(8'hFF);
    dir_frame.push_back(8'h00);
    dir_frame.push_back(TAIL_MARK);
    dir_frame.push_back(TAIL_MARK);
    acc = '0;
    foreach (dir_frame[i]) acc = crc8_next(acc, dir_frame[i]);
    dir_frame.push_back(acc);
    foreach (dir_frame[i]) push_byte(dir_frame[i], i == 0, 1'b0);
    // Bad header at the first byte, then at the second; id and length read as zero.
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(HDR_MARK, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    // Idle bytes with no frame open: no verdict.
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    live_bytes = 23;

    // Random frames, good ones most often, with every fault, restarts and noise mixed in.
    frame_no = 0;
    while (live_bytes < LIVE_TARGET) begin
      roll = $urandom_range(0, 99);
      if      (roll < 38) kind = FRM_GOOD;
      else if (roll < 50) kind = FRM_CRC_BAD;
      else if (roll < 58) kind = FRM_BAD_TAIL0;
      else if (roll < 66) kind = FRM_BAD_TAIL1;
      else if (roll < 74) kind = FRM_LEN_BIG;
      else if (roll < 80) kind = FRM_BAD_HDR0;
      else if (roll < 86) kind = FRM_BAD_HDR1;
      else if (roll < 95) kind = FRM_RESTART;
      else                kind = FRM_NOISE;
      add_frame(kind, (frame_no % 15) == 14);
      frame_no++;
    end
    byte_total = byte_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every byte to transfer, then for the verdicts to drain.
    while (sent_cnt < byte_total) @(posedge clk);
    for (int n = 0; n < 5000 && verdict_q.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d verdicts never arrived, expected verdict=%0d id=%02h len=%02h",
               $time, verdict_q.size(), verdict_q[0].verdict, verdict_q[0].trans_id,
               verdict_q[0].payload_len);
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/rfc_pkg.sv
design/rfc_in_stage.sv
design/rfc_check.sv
design/rfc_out_stage.sv
design/rs485_frame_checker_crc8_top.sv
tb/rs485_frame_checker_crc8_top_tb.sv
